/* rtl/core/adr_pkg.sv */
// Shared types, widths and constants for the ADC average / delta reporter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package adr_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W   = 11;  // signed converter reading
  localparam int unsigned AVG_W      = 10;
  localparam int unsigned MULT_W     = 7;
  localparam int unsigned TRIG_W     = 16;
  localparam int unsigned PROD_W     = AVG_W + MULT_W;  // average * multiplier
  localparam int unsigned VOLT_W     = 20;
  localparam int unsigned VNUM_W     = 23;  // product * 50

  // Stream and configuration port widths
  localparam int unsigned S_TDATA_W  = 16;
  localparam int unsigned M_TDATA_W  = 40;
  localparam int unsigned M_TUSER_W  = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned RING_DEPTH_DEFAULT = 8;

  // Constants
  localparam logic [AVG_W-1:0]  SAMPLE_SATURATED = 10'd1023;
  localparam logic [MULT_W-1:0] MULT_RESET       = 7'd10;
  localparam logic [3:0]        VOLT_DIVISOR     = 4'd9;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_MULT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELTA_TRIG = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_VOLT_GO,
    ST_VOLT_WAIT,
    ST_DONE
  } state_e;

  // x * 50 = x*32 + x*16 + x*2
  function automatic logic [VNUM_W-1:0] times50(input logic [PROD_W-1:0] x);
    logic [VNUM_W-1:0] w;
    w = VNUM_W'(x);
    return (w << 5) + (w << 4) + (w << 1);
  endfunction

  // x * 9 = x*8 + x
  function automatic logic [VOLT_W-1:0] times9(input logic [TRIG_W-1:0] x);
    logic [VOLT_W-1:0] w;
    w = VOLT_W'(x);
    return (w << 3) + w;
  endfunction

endpackage

/* rtl/core/adr_serial_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle, MSB first.
// Depends on adr_pkg (dividend width).
`timescale 1ns / 1ps

module adr_serial_div #(
  parameter int unsigned DVS_W = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [adr_pkg::VNUM_W-1:0] dividend_i,
  input  logic [DVS_W-1:0]          divisor_i,
  output logic [adr_pkg::VNUM_W-1:0] quotient_o,
  output logic                      done_o
);
  import adr_pkg::*;

  localparam int unsigned CNT_W = $clog2(VNUM_W);

  logic [VNUM_W-1:0] dvd_q, dvd_d;   // dividend bits out, quotient bits in
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DVS_W-1:0]  dvs_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;
  logic [DVS_W:0]    trial, trial_sub;
  logic              fits;

  assign trial     = {rem_q, dvd_q[VNUM_W-1]};
  assign trial_sub = trial - {1'b0, dvs_q};
  assign fits      = (trial >= {1'b0, dvs_q});
  assign rem_d     = fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
  assign dvd_d     = {dvd_q[VNUM_W-2:0], fits};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(VNUM_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o = dvd_q;
  assign done_o     = done_q;

endmodule

/* rtl/core/adr_serial_mul.sv */
// Bit-serial shift-add multiplier: average times voltage multiplier.
// Depends on adr_pkg (operand widths).
`timescale 1ns / 1ps

module adr_serial_mul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [adr_pkg::AVG_W-1:0]  a_i,
  input  logic [adr_pkg::MULT_W-1:0] b_i,
  output logic [adr_pkg::PROD_W-1:0] product_o,
  output logic                       done_o
);
  import adr_pkg::*;

  localparam int unsigned CNT_W = $clog2(MULT_W);

  logic [PROD_W-1:0] acc_q, mcand_q;
  logic [MULT_W-1:0] mplier_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(MULT_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q    <= '0;
      mcand_q  <= PROD_W'(a_i);
      mplier_q <= b_i;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
    end
  end

  assign product_o = acc_q;
  assign done_o    = done_q;

endmodule

/* rtl/core/adc_average_delta_reporter.sv */
// Top level of the ADC average / delta reporter: sequencer, ring memory, state.
// Depends on adr_pkg, adr_serial_div and adr_serial_mul.
`timescale 1ns / 1ps

// Usage
//  s_axis: one converter sample per request, tdata[10:0] signed. Readings
//    outside 0..1022 (read failure, saturation) are rejected and leave the
//    state alone; their result has every field zero.
//  m_axis: one result per sample. tuser = {delta_send, accepted};
//    tdata = {voltage_tenths_mv, deviation, average_adc}.
//  cfg: write channel, always ready. Index 0 voltage multiplier (7 bits),
//    index 1 delta trigger (16 bits); other indexes ignored. Write only idle.
//  Sequencing: one sample at a time. A rejected sample goes straight to the
//    result state; an accepted one reads the ring, updates the sum, then runs
//    the bit-serial divider (average), the shift-add multiplier and the
//    divider again (volts / 9). s_axis_tready is high only when idle, so a new
//    request is taken only after the previous result is in the output register.
//  Stall: the result sits in an output register; the next sample is taken
//    while it waits, and its result is held back until the register frees.
//  Reset: asynchronous, active low. Sum, fill count, position, average and
//    reference clear; multiplier returns to 10, trigger to 0 (disabled).
//    Ring entries are not cleared: an old entry is used only once all are written.

module adc_average_delta_reporter #(
  parameter int unsigned RING_DEPTH = adr_pkg::RING_DEPTH_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // sample in
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [adr_pkg::S_TDATA_W-1:0]  s_axis_tdata,   // [10:0] adc_sample
  // result out
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [adr_pkg::M_TDATA_W-1:0]  m_axis_tdata,   // [9:0] average_adc,
                                                         // [19:10] deviation,
                                                         // [39:20] voltage_tenths_mv
  output logic [adr_pkg::M_TUSER_W-1:0]  m_axis_tuser,   // [0] accepted, [1] delta_send
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [adr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [adr_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import adr_pkg::*;

  localparam int unsigned POS_W  = $clog2(RING_DEPTH);
  localparam int unsigned FILL_W = $clog2(RING_DEPTH + 1);
  localparam int unsigned SUM_W  = $clog2(RING_DEPTH * 1022 + 1);
  localparam int unsigned DVS_W  = (FILL_W > 4) ? FILL_W : 4;

  state_e state_q, state_d;

  // configuration
  logic [MULT_W-1:0] mult_q;
  logic [TRIG_W-1:0] trig_q;

  // filter state
  logic [SUM_W-1:0]  sum_q;
  logic [FILL_W-1:0] fill_q;
  logic [POS_W-1:0]  wpos_q;
  logic [AVG_W-1:0]  avg_q;
  logic              has_ref_q;
  logic [PROD_W-1:0] ref_q;

  // per-sample working registers
  logic [AVG_W-1:0]  raw_q;
  logic              acc_q;
  logic [AVG_W-1:0]  dev_q;
  logic [AVG_W-1:0]  oldest_q;
  logic [DVS_W-1:0]  dvs_q;
  logic [PROD_W-1:0] prod_q;
  logic [PROD_W-1:0] diff_q;
  logic [VOLT_W-1:0] volt_q;
  logic              send_q;

  // ring memory
  logic [AVG_W-1:0]  ring_q [RING_DEPTH];

  // output register
  logic                 out_valid_q;
  logic [M_TDATA_W-1:0] out_data_q;
  logic [M_TUSER_W-1:0] out_user_q;

  // control
  logic in_fire, out_free, load_out;
  logic div_start, mul_start;
  logic div_done, mul_done;
  logic [VNUM_W-1:0] div_dividend, div_quot;
  logic [DVS_W-1:0]  div_divisor;
  logic [PROD_W-1:0] mul_prod;

  // accept-time decode
  logic              in_ok;
  logic [AVG_W-1:0]  in_raw;
  logic [AVG_W-1:0]  in_dev;

  // sum update
  logic              ring_full;
  logic [SUM_W:0]    sum_add, sum_new;

  // delta compare
  logic              trig_hit;

  assign in_raw   = s_axis_tdata[AVG_W-1:0];
  // sign bit set or saturated reading: reject
  assign in_ok    = !s_axis_tdata[SAMPLE_W-1] && (in_raw != SAMPLE_SATURATED);
  assign in_dev   = (fill_q == '0) ? '0 :
                    (in_raw > avg_q) ? (in_raw - avg_q) : (avg_q - in_raw);

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  assign ring_full = (fill_q == FILL_W'(RING_DEPTH));
  assign sum_add   = {1'b0, sum_q} + (SUM_W + 1)'(raw_q);
  assign sum_new   = ring_full ? (sum_add - (SUM_W + 1)'(oldest_q)) : sum_add;

  assign trig_hit  = times50(diff_q) > VNUM_W'(times9(trig_q));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = in_ok ? ST_READ : ST_DONE;
        end
      end
      ST_READ:      state_d = ST_SUM;
      ST_SUM:       state_d = ST_AVG_GO;
      ST_AVG_GO:    state_d = ST_AVG_WAIT;
      ST_AVG_WAIT:  if (div_done) state_d = ST_MUL_GO;
      ST_MUL_GO:    state_d = ST_MUL_WAIT;
      ST_MUL_WAIT:  if (mul_done) state_d = ST_VOLT_GO;
      ST_VOLT_GO:   state_d = ST_VOLT_WAIT;
      ST_VOLT_WAIT: if (div_done) state_d = ST_DONE;
      ST_DONE:      if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    mul_start     = 1'b0;
    load_out      = 1'b0;
    div_dividend  = VNUM_W'(sum_q);
    div_divisor   = dvs_q;
    case (state_q)
      ST_IDLE:    s_axis_tready = 1'b1;
      ST_AVG_GO:  div_start = 1'b1;
      ST_MUL_GO:  mul_start = 1'b1;
      ST_VOLT_GO: begin
        div_start    = 1'b1;
        div_dividend = times50(prod_q);
        div_divisor  = DVS_W'(VOLT_DIVISOR);
      end
      ST_DONE:    load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_q <= MULT_RESET;
      trig_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_VOLT_MULT:  mult_q <= cfg_data_i[MULT_W-1:0];
        REG_DELTA_TRIG: trig_q <= cfg_data_i[TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  // ring: read-first, oldest entry captured before overwrite
  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      oldest_q       <= ring_q[wpos_q];
      ring_q[wpos_q] <= raw_q;
    end
  end

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      fill_q    <= '0;
      wpos_q    <= '0;
      avg_q     <= '0;
      has_ref_q <= 1'b0;
      ref_q     <= '0;
    end else begin
      if (state_q == ST_SUM) begin
        sum_q  <= sum_new[SUM_W-1:0];
        wpos_q <= (wpos_q == POS_W'(RING_DEPTH - 1)) ? '0 : wpos_q + 1'b1;
        if (!ring_full) begin
          fill_q <= fill_q + 1'b1;
        end
      end
      if (state_q == ST_AVG_WAIT && div_done) begin
        avg_q <= div_quot[AVG_W-1:0];
      end
      // reference kept when trigger is zero
      if (state_q == ST_VOLT_WAIT && div_done && trig_q != '0) begin
        if (!has_ref_q) begin
          has_ref_q <= 1'b1;
          ref_q     <= prod_q;
        end else if (trig_hit) begin
          ref_q <= prod_q;
        end
      end
    end
  end

  // per-sample working registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      raw_q  <= in_raw;
      acc_q  <= in_ok;
      dev_q  <= in_dev;
      send_q <= 1'b0;
    end
    if (state_q == ST_SUM) begin
      dvs_q <= ring_full ? DVS_W'(RING_DEPTH) : DVS_W'(fill_q) + 1'b1;
    end
    if (state_q == ST_MUL_WAIT && mul_done) begin
      prod_q <= mul_prod;
    end
    if (state_q == ST_VOLT_GO) begin
      diff_q <= (prod_q > ref_q) ? (prod_q - ref_q) : (ref_q - prod_q);
    end
    if (state_q == ST_VOLT_WAIT && div_done) begin
      volt_q <= div_quot[VOLT_W-1:0];
      send_q <= (trig_q != '0) && has_ref_q && trig_hit;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      if (acc_q) begin
        out_data_q <= {volt_q, dev_q, avg_q};
        out_user_q <= {send_q, 1'b1};
      end else begin
        out_data_q <= '0;
        out_user_q <= '0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  adr_serial_div #(
    .DVS_W(DVS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quot),
    .done_o     (div_done)
  );

  adr_serial_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       (avg_q),
    .b_i       (mult_q),
    .product_o (mul_prod),
    .done_o    (mul_done)
  );

endmodule

/* tb/testbench.sv */
// Self-checking bench for adc_average_delta_reporter: a predictor of the moving average,
// voltage and delta report, random stream stalls and register phases.
// Depends on adr_pkg and the block's RTL.
`timescale 1ns / 1ps

typedef struct packed {
  logic        accepted;
  logic        delta_send;
  logic [9:0]  average_adc;
  logic [9:0]  deviation;
  logic [19:0] voltage_tenths_mv;
} report_t;

// Predicts one report per sample request and checks the block's reports in order.
class average_predictor;
  localparam int unsigned DEPTH = adr_pkg::RING_DEPTH_DEFAULT;

  logic [9:0]  ring [DEPTH];
  logic [12:0] running_sum;
  int unsigned fill_count;
  int unsigned write_pos;
  logic [9:0]  average;
  logic        has_ref;
  logic [16:0] ref_product;
  logic [6:0]  multiplier;
  logic [15:0] trigger;

  report_t     expected_reports [$];
  int unsigned mismatches;

  function new();
    foreach (ring[i]) ring[i] = '0;
    running_sum = '0;
    fill_count  = 0;
    write_pos   = 0;
    average     = '0;
    has_ref     = 1'b0;
    ref_product = '0;
    multiplier  = adr_pkg::MULT_RESET;
    trigger     = '0;
    mismatches  = 0;
  endfunction

  function void write_reg(logic [adr_pkg::CFG_IDX_W-1:0] idx,
                          logic [adr_pkg::CFG_DATA_W-1:0] data);
    if (idx == adr_pkg::REG_VOLT_MULT) multiplier = data[6:0];
    else if (idx == adr_pkg::REG_DELTA_TRIG) trigger = data;
  endfunction

  function void note_sample(logic [10:0] raw);
    report_t     rep;
    logic [9:0]  sample;
    logic [9:0]  oldest;
    logic [16:0] prod;
    logic [16:0] diff;
    logic [22:0] volt_num;
    rep = '0;
    // read failure, saturation and any other negative pattern: state untouched
    if (raw > 11'd1022) begin
      expected_reports.push_back(rep);
      return;
    end
    sample = raw[9:0];
    if (fill_count != 0)
      rep.deviation = (sample > average) ? sample - average : average - sample;
    oldest = ring[write_pos];
    ring[write_pos] = sample;
    running_sum = running_sum + 13'(sample);
    if (fill_count < DEPTH) begin
      average = 10'(running_sum / 13'(fill_count + 1));
      fill_count++;
    end else begin
      running_sum = running_sum - 13'(oldest);
      average = 10'(running_sum / 13'(DEPTH));
    end
    write_pos = (write_pos + 1) % DEPTH;

    prod     = 17'(average) * 17'(multiplier);
    volt_num = 23'(prod) * 23'd50;
    rep.voltage_tenths_mv = 20'(volt_num / 23'd9);

    // zero trigger: no report, but an existing reference survives
    if (trigger != 0) begin
      if (!has_ref) begin
        ref_product = prod;
        has_ref     = 1'b1;
      end else begin
        diff = (prod > ref_product) ? prod - ref_product : ref_product - prod;
        if (23'(diff) * 23'd50 > 23'(trigger) * 23'd9) begin
          rep.delta_send = 1'b1;
          ref_product    = prod;
        end
      end
    end
    rep.accepted    = 1'b1;
    rep.average_adc = average;
    expected_reports.push_back(rep);
  endfunction

  function void flag(string what, logic [19:0] exp, logic [19:0] act);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch %s: expected %0d, got %0d", $realtime, what, exp, act);
  endfunction

  function void check_result(logic [adr_pkg::M_TDATA_W-1:0] tdata,
                             logic [adr_pkg::M_TUSER_W-1:0] tuser);
    report_t exp;
    if (expected_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("%0t report with none outstanding", $realtime);
      return;
    end
    exp = expected_reports.pop_front();
    if (tuser[0] !== exp.accepted) flag("accepted", exp.accepted, tuser[0]);
    if (tuser[1] !== exp.delta_send) flag("delta_send", exp.delta_send, tuser[1]);
    if (tdata[9:0] !== exp.average_adc) flag("average_adc", exp.average_adc, tdata[9:0]);
    if (tdata[19:10] !== exp.deviation) flag("deviation", exp.deviation, tdata[19:10]);
    if (tdata[39:20] !== exp.voltage_tenths_mv)
      flag("voltage_tenths_mv", exp.voltage_tenths_mv, tdata[39:20]);
  endfunction

  function int unsigned pending();
    return expected_reports.size();
  endfunction
endclass

module testbench;
  import adr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 65;
  localparam int unsigned TAIL_CYCLES = 80;
  // indexes the block must ignore
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata;   // [10:0] adc_sample
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [M_TDATA_W-1:0]  m_axis_tdata;   // [9:0] average_adc, [19:10] deviation,
                                         // [39:20] voltage_tenths_mv
  logic [M_TUSER_W-1:0]  m_axis_tuser;   // [0] accepted, [1] delta_send
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  average_predictor sb;
  logic        calm;          // no idling on either side while set
  int unsigned cycles;
  int          level;         // centre of the random walk that feeds samples

  adc_average_delta_reporter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side stalls at random (tready low with probability 22 in 100), except in the calm stretch.
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 22);
  end

  // One process observes every handshake, so the predictor sees requests,
  // register writes and reports in edge order.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) sb.note_sample(s_axis_tdata[10:0]);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  // Present one sample request, with random idle cycles first, and hold it until taken.
  // tvalid stays high on return so back-to-back requests need no extra edge.
  task automatic send_sample(logic [10:0] sample);
    while (!calm && $urandom_range(0, 99) < 22) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_TDATA_W-11){1'b0}}, sample};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stop sending and wait until every outstanding report is back.
  // Polled on the falling edge to stay clear of the monitor's update.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // New phase: multiplier data carries junk in its unused upper bits, and
  // the spare indexes get a write now and then.
  task automatic set_phase(logic [6:0] mult, logic [15:0] trig);
    drain();
    write_reg(REG_VOLT_MULT, {9'($urandom_range(0, 511)), mult});
    write_reg(REG_DELTA_TRIG, trig);
    if ($urandom_range(0, 1) == 1)
      write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, 16'($urandom));
  endtask

  // Mostly a noisy random walk with jumps (drives delta reports), plus
  // full-scale values and rejected patterns.
  function logic [10:0] pick_sample();
    int unsigned roll;
    int          v;
    roll = $urandom_range(0, 99);
    if (roll < 4) return 11'h7FF;                          // read failure
    if (roll < 7) return 11'd1023;                         // saturated
    if (roll < 10) return 11'($urandom_range(1024, 2047)); // other negatives
    if (roll < 14) return 11'd0;
    if (roll < 18) return 11'd1022;
    if (roll < 28) return 11'($urandom_range(0, 1022));
    if (roll < 34) level = $urandom_range(0, 1022);
    v = level + $urandom_range(0, 40) - 20;
    if (v < 0) v = 0;
    if (v > 1022) v = 1022;
    return 11'(v);
  endfunction

  initial begin
    logic [10:0] smp;
    logic [6:0]  mults [6];
    logic [15:0] trigs [6];
    int unsigned sent;

    sb            = new();
    cycles        = 0;
    calm          = 1'b0;
    level         = 512;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, full-scale multiplier via junk upper bits,
    // first sample with no deviation, every rejected flavour, ring fill then wrap.
    send_sample(11'd0);
    drain();
    write_reg(REG_VOLT_MULT, 16'hFFFF);
    send_sample(11'd1022);
    send_sample(11'h7FF);
    send_sample(11'd1023);
    send_sample(11'h400);
    send_sample(11'h5A5);
    repeat (6) send_sample(11'd1022);
    send_sample(11'd0);   // ring full: oldest entry drops out
    send_sample(11'd1022);

    // Smallest trigger: first sample takes the reference, the next moves the
    // product and reports, and one that leaves the product equal stays quiet.
    set_phase(7'd10, 16'd1);
    send_sample(11'd500);
    send_sample(11'd500);
    send_sample(11'd1022);
    send_sample(11'h7FF);
    // Trigger back to zero: no report, reference kept for later
    set_phase(7'd10, 16'd0);
    send_sample(11'd100);
    send_sample(11'd0);
    // Largest trigger, then zero multiplier
    set_phase(7'd127, 16'hFFFF);
    send_sample(11'd1022);
    send_sample(11'd0);
    drain();
    write_reg(REG_SPARE_2, 16'hFFFF);
    write_reg(REG_SPARE_3, 16'h0000);
    set_phase(7'd0, 16'd7);
    send_sample(11'd600);
    send_sample(11'd1022);

    // Random phases over several register settings
    mults = '{7'd10, 7'd127, 7'd0, 7'd1, 7'($urandom_range(0, 127)),
              7'($urandom_range(0, 127))};
    trigs = '{16'd200, 16'hFFFF, 16'd5, 16'd1, 16'($urandom_range(0, 4000)), 16'd0};
    for (int p = 0; p < 6; p++) begin
      set_phase(mults[p], trigs[p]);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        calm <= (p == 3) && (sent < 60);
        // hold the sender back until the block has caught up completely
        if ((p == 2 && sent == PHASE_ITEMS / 2) || $urandom_range(0, 99) == 0) drain();
        smp = pick_sample();
        send_sample(smp);
        if (smp <= 11'd1022) sent++;
      end
    end
    calm <= 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.mismatches++;
      $display("%0d reports never arrived", sb.pending());
    end
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
